@@ sv/b64e_pkg.sv @@
// Shared types, constants and the alphabet function of the Base64 encoder.
`default_nettype none
package b64e_pkg;

	localparam int GRP_DEPTH = 2;
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam logic [1:0] CHAR_0 = 2'd0;
	localparam logic [1:0] CHAR_1 = 2'd1;
	localparam logic [1:0] CHAR_2 = 2'd2;
	localparam logic [1:0] CHAR_3 = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       end_of_text;
	} out_item_t;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] n;
		logic       fin;
	} grp_t;

	function automatic logic [7:0] enc_char(input logic [5:0] six);
		logic [7:0] v;
		v = {2'b00, six};
		if (six < 6'd26)
			enc_char = 8'h41 + v;
		else if (six < 6'd52)
			enc_char = 8'h61 + v - 8'd26;
		else if (six < 6'd62)
			enc_char = 8'h30 + v - 8'd52;
		else if (six == 6'd62)
			enc_char = 8'h2B;
		else
			enc_char = 8'h2F;
	endfunction

endpackage
`default_nettype wire

@@ sv/b64e_front.sv @@
// Front end: collects bytes into groups and pushes complete or final groups.
`default_nettype none
module b64e_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire b64e_pkg::in_item_t in_data,
	input  wire logic              grp_full,
	output logic                   grp_push,
	output b64e_pkg::grp_t         grp_data
);

	logic [7:0] first_q;
	logic [7:0] second_q;
	logic [1:0] cnt_q;
	logic [1:0] have;
	logic [1:0] n;
	logic       accept;
	logic       hold;

	assign accept = push && !grp_full;
	assign have   = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
	assign n      = have + 2'd1;
	assign hold   = (n != 2'd3) && !in_data.final_byte;

	assign grp_push = accept && !hold;

	always_comb begin
		grp_data.n   = n;
		grp_data.fin = in_data.final_byte;
		grp_data.b0  = (n == 2'd1) ? in_data.data_byte : first_q;
		grp_data.b1  = (n == 2'd2) ? in_data.data_byte : ((n == 2'd3) ? second_q : 8'd0);
		grp_data.b2  = (n == 2'd3) ? in_data.data_byte : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			first_q  <= 8'd0;
			second_q <= 8'd0;
		end else if (accept) begin
			cnt_q <= hold ? n : 2'd0;
			if (hold) begin
				if (have == 2'd0)
					first_q <= in_data.data_byte;
				else
					second_q <= in_data.data_byte;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/b64e_grpq.sv @@
// Short group queue between front end and character back end.
`default_nettype none
module b64e_grpq #(
	parameter int DEPTH = b64e_pkg::GRP_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire b64e_pkg::grp_t wr_data,
	output logic                full,
	input  wire logic           rd_en,
	output logic                empty,
	output b64e_pkg::grp_t      rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64e_pkg::grp_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

@@ sv/b64e_back.sv @@
// Back end: turns each queued group into four characters, one per cycle while the result side pops.
`default_nettype none
module b64e_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              grp_empty,
	input  wire b64e_pkg::grp_t    grp_data,
	output logic                   grp_pop,
	input  wire logic              pop,
	output logic                   empty,
	output b64e_pkg::out_item_t    out_data
);

	logic                valid_q;
	b64e_pkg::out_item_t out_q;
	logic [1:0]          k_q;
	logic                load;
	logic [5:0]          six;
	logic [23:0]         bits;
	b64e_pkg::out_item_t nxt;

	assign empty    = !valid_q;
	assign out_data = out_q;
	assign load     = !grp_empty && (!valid_q || pop);
	assign grp_pop  = load && (k_q == b64e_pkg::CHAR_3);
	assign bits     = {grp_data.b0, grp_data.b1, grp_data.b2};

	always_comb begin
		case (k_q)
			b64e_pkg::CHAR_0: six = bits[23:18];
			b64e_pkg::CHAR_1: six = bits[17:12];
			b64e_pkg::CHAR_2: six = bits[11:6];
			default:          six = bits[5:0];
		endcase
		nxt.out_char    = (k_q <= grp_data.n) ? b64e_pkg::enc_char(six) : b64e_pkg::PAD_CHAR;
		nxt.end_of_text = grp_data.fin && (k_q == b64e_pkg::CHAR_3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= b64e_pkg::CHAR_0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				k_q     <= k_q + 2'd1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= nxt;
	end

endmodule
`default_nettype wire

@@ sv/base64_encoder_core.sv @@
// Top level of the streaming Base64 encoder.
//
// Channel   Handshake    Payload
// input     push / full  in_data  (data_byte, final_byte)
// result    pop / empty  out_data (out_char, end_of_text)
//
// A byte is taken every cycle while the group queue has room; a finished group
// yields four characters, so the sustained byte rate is set by the back end
// emitting one character per cycle while the result side pops.
// Each result character is registered into out_q from the group at the queue head.
// Reset clears the held count, the queue pointers and the output valid.
// A stall on the result side fills the queue, then raises full.
`default_nettype none
module base64_encoder_core #(
	parameter int GRP_DEPTH = b64e_pkg::GRP_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire b64e_pkg::in_item_t in_data,
	output logic                    empty,
	input  wire logic               pop,
	output b64e_pkg::out_item_t     out_data
);

	logic           grp_push;
	logic           grp_full;
	logic           grp_pop;
	logic           grp_empty;
	b64e_pkg::grp_t grp_wr;
	b64e_pkg::grp_t grp_rd;

	assign full = grp_full;

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_data  (in_data),
		.grp_full (grp_full),
		.grp_push (grp_push),
		.grp_data (grp_wr)
	);

	b64e_grpq #(
		.DEPTH (GRP_DEPTH)
	) u_grpq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (grp_push),
		.wr_data (grp_wr),
		.full    (grp_full),
		.rd_en   (grp_pop),
		.empty   (grp_empty),
		.rd_data (grp_rd)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_empty (grp_empty),
		.grp_data  (grp_rd),
		.grp_pop   (grp_pop),
		.pop       (pop),
		.empty     (empty),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
